@@ hdl/sttok_pkg.sv @@
// Shared types and constants for the source text tokenizer.
// Holds the channel word structs, the token kind codes and the lexer mode enum.
// No dependencies.
`default_nettype none

package sttok_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int LENGTH_BITS = 16;
    localparam int KIND_BITS   = 6;

    // Result queue between the lexer and the output channel.
    localparam int OQ_DEPTH    = 4;
    localparam int OQ_PTR_BITS = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_BITS = $clog2(OQ_DEPTH + 1);

    typedef logic [KIND_BITS-1:0] t_kind;

    localparam t_kind K_END       = 6'd0;
    localparam t_kind K_INVALID   = 6'd1;
    localparam t_kind K_UNTERM    = 6'd2;
    localparam t_kind K_IDENT     = 6'd3;
    localparam t_kind K_INT       = 6'd4;
    localparam t_kind K_FLOAT     = 6'd5;
    localparam t_kind K_CHAR      = 6'd6;
    localparam t_kind K_STRING    = 6'd7;
    localparam t_kind P_LPAREN    = 6'd8;
    localparam t_kind P_RPAREN    = 6'd9;
    localparam t_kind P_LBRACK    = 6'd10;
    localparam t_kind P_RBRACK    = 6'd11;
    localparam t_kind P_LBRACE    = 6'd12;
    localparam t_kind P_RBRACE    = 6'd13;
    localparam t_kind P_COMMA     = 6'd14;
    localparam t_kind P_SEMI      = 6'd15;
    localparam t_kind P_COLON     = 6'd16;
    localparam t_kind P_SCOPE     = 6'd17;
    localparam t_kind P_DOT       = 6'd18;
    localparam t_kind P_RANGE     = 6'd19;
    localparam t_kind P_ELLIPSIS  = 6'd20;
    localparam t_kind P_LT        = 6'd21;
    localparam t_kind P_SHL       = 6'd22;
    localparam t_kind P_SHL_EQ    = 6'd23;
    localparam t_kind P_LE        = 6'd24;
    localparam t_kind P_GT        = 6'd25;
    localparam t_kind P_SHR       = 6'd26;
    localparam t_kind P_SHR_EQ    = 6'd27;
    localparam t_kind P_GE        = 6'd28;
    localparam t_kind P_MOD       = 6'd29;
    localparam t_kind P_MOD_EQ    = 6'd30;
    localparam t_kind P_XOR       = 6'd31;
    localparam t_kind P_XOR_EQ    = 6'd32;
    localparam t_kind P_AMP       = 6'd33;
    localparam t_kind P_LAND      = 6'd34;
    localparam t_kind P_LAND_EQ   = 6'd35;
    localparam t_kind P_AND_EQ    = 6'd36;
    localparam t_kind P_STAR      = 6'd37;
    localparam t_kind P_STAR_EQ   = 6'd38;
    localparam t_kind P_MINUS     = 6'd39;
    localparam t_kind P_MINUS_EQ  = 6'd40;
    localparam t_kind P_ARROW     = 6'd41;
    localparam t_kind P_ASSIGN    = 6'd42;
    localparam t_kind P_EQEQ      = 6'd43;
    localparam t_kind P_DARROW    = 6'd44;
    localparam t_kind P_PIPE      = 6'd45;
    localparam t_kind P_LOR       = 6'd46;
    localparam t_kind P_LOR_EQ    = 6'd47;
    localparam t_kind P_OR_EQ     = 6'd48;
    localparam t_kind P_PLUS      = 6'd49;
    localparam t_kind P_PLUS_EQ   = 6'd50;
    localparam t_kind P_QUEST     = 6'd51;
    localparam t_kind P_BANG      = 6'd52;
    localparam t_kind P_NE        = 6'd53;
    localparam t_kind P_SLASH     = 6'd54;
    localparam t_kind P_SLASH_EQ  = 6'd55;

    typedef enum logic [4:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_QUOTE, M_LINE, M_BLOCK,
        M_DOT1, M_DOT2, M_SLASH, M_COLON, M_LT, M_LT2, M_GT, M_GT2,
        M_DOLLAR, M_CARET, M_AMP, M_AMP2, M_STAR, M_MINUS, M_EQ,
        M_PIPE, M_PIPE2, M_PLUS, M_BANG
    } t_mode;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } t_in_word;

    typedef struct packed {
        t_kind                  token_kind;
        logic [OFFSET_BITS-1:0] start_offset;
        logic [LENGTH_BITS-1:0] token_length;
        logic                   last_of_run;
    } t_out_word;

endpackage

`default_nettype wire

@@ hdl/source_text_tokenizer.sv @@
// Source text tokenizer: one byte in, up to two tokens out, through a small result queue.
// Depends on sttok_pkg for the word structs, token kinds and lexer modes.
//
// Usage: source bytes enter on the input channel (i_in_valid, o_in_stall, i_in_word), one
// word per byte; a zero byte or end_of_text closes the text. Tokens leave on the output
// channel (o_out_valid, i_out_stall, o_out_word) as kind, start offset and length, with
// last_of_run set on the final token caused by a byte. Bytes that only extend a token or
// are skipped give no output word.
// Throughput: one byte per clock while o_in_stall is low. The lexer state registers are
// updated by one pass of short decode logic per accepted byte, and the tokens are written
// into a four-entry queue. A token is written into the queue when the byte that completes
// it is accepted; a byte that yields two tokens writes both words at once, and the queue
// absorbs the extra word. The input stalls while the queue holds three or more words, so
// that a stall on the output side backs up into the input without loss.
// Reset (synchronous, active low) empties the queue and returns the lexer to idle at
// offset zero. The end token also returns the lexer to that state for the next text.
`default_nettype none

module source_text_tokenizer (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  sttok_pkg::t_in_word   i_in_word,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output sttok_pkg::t_out_word  o_out_word
);

    localparam int LB = sttok_pkg::LENGTH_BITS;
    localparam int OB = sttok_pkg::OFFSET_BITS;

    // Lexer state.
    sttok_pkg::t_mode   r_mode, n_mode;
    logic [OB-1:0]      r_byte_pos, n_byte_pos;
    logic [OB-1:0]      r_tok_start, n_tok_start;
    logic [LB-1:0]      r_run_len, n_run_len;
    logic               r_escape, n_escape;
    logic               r_qdouble, n_qdouble;
    logic               r_dot_seen, n_dot_seen;
    logic               r_star_seen, n_star_seen;

    // Result queue.
    sttok_pkg::t_out_word                r_oq [sttok_pkg::OQ_DEPTH];
    logic [sttok_pkg::OQ_PTR_BITS-1:0]   r_wr_ptr, r_rd_ptr;
    logic [sttok_pkg::OQ_CNT_BITS-1:0]   r_count, n_count;

    logic [7:0]         w_c;
    logic               w_eot;
    logic               w_in_acc;
    logic               w_out_acc;
    logic               w_alpha, w_digit, w_alnum;
    logic [LB-1:0]      w_grown;
    logic               w_close;
    logic               w_restart;

    // Lookahead decode for punctuator modes.
    logic               ext_take, ext_fin;
    sttok_pkg::t_kind   ext_kind;
    sttok_pkg::t_mode   ext_next;

    // Decode of a byte that starts a new token.
    logic               s_open, s_emit;
    sttok_pkg::t_kind   s_kind;
    sttok_pkg::t_mode   s_mode;

    // Up to two tokens per byte: slot a from the pending token, slot b from this byte.
    logic               a_vld, b_vld;
    sttok_pkg::t_kind   a_kind, b_kind;
    logic [OB-1:0]      a_start, b_start;
    logic [LB-1:0]      a_len, b_len;
    sttok_pkg::t_out_word w_res0, w_res1;
    logic [1:0]         w_nres;

    function automatic sttok_pkg::t_kind held_kind(input sttok_pkg::t_mode m);
        sttok_pkg::t_kind k;
        unique case (m)
            sttok_pkg::M_DOT1:   k = sttok_pkg::P_DOT;
            sttok_pkg::M_DOT2:   k = sttok_pkg::P_RANGE;
            sttok_pkg::M_SLASH:  k = sttok_pkg::P_SLASH;
            sttok_pkg::M_COLON:  k = sttok_pkg::P_COLON;
            sttok_pkg::M_LT:     k = sttok_pkg::P_LT;
            sttok_pkg::M_LT2:    k = sttok_pkg::P_SHL;
            sttok_pkg::M_GT:     k = sttok_pkg::P_GT;
            sttok_pkg::M_GT2:    k = sttok_pkg::P_SHR;
            sttok_pkg::M_DOLLAR: k = sttok_pkg::P_MOD;
            sttok_pkg::M_CARET:  k = sttok_pkg::P_XOR;
            sttok_pkg::M_AMP:    k = sttok_pkg::P_AMP;
            sttok_pkg::M_AMP2:   k = sttok_pkg::P_LAND;
            sttok_pkg::M_STAR:   k = sttok_pkg::P_STAR;
            sttok_pkg::M_MINUS:  k = sttok_pkg::P_MINUS;
            sttok_pkg::M_EQ:     k = sttok_pkg::P_ASSIGN;
            sttok_pkg::M_PIPE:   k = sttok_pkg::P_PIPE;
            sttok_pkg::M_PIPE2:  k = sttok_pkg::P_LOR;
            sttok_pkg::M_PLUS:   k = sttok_pkg::P_PLUS;
            default:             k = sttok_pkg::P_BANG;
        endcase
        return k;
    endfunction

    // Bytes already held by a punctuator mode.
    function automatic logic [LB-1:0] held_len(input sttok_pkg::t_mode m);
        logic two;
        two = (m == sttok_pkg::M_DOT2) || (m == sttok_pkg::M_LT2) ||
              (m == sttok_pkg::M_GT2) || (m == sttok_pkg::M_AMP2) ||
              (m == sttok_pkg::M_PIPE2);
        return two ? LB'(2) : LB'(1);
    endfunction

    assign w_c       = i_in_word.char_code;
    assign w_eot     = i_in_word.end_of_text || (w_c == 8'd0);
    assign o_in_stall = (r_count > sttok_pkg::OQ_CNT_BITS'(sttok_pkg::OQ_DEPTH - 2));
    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_count != '0);
    assign o_out_word  = r_oq[r_rd_ptr];
    assign w_out_acc = o_out_valid && !i_out_stall;

    assign w_alpha = (w_c >= "a" && w_c <= "z") || (w_c >= "A" && w_c <= "Z") || (w_c == "_");
    assign w_digit = (w_c >= "0" && w_c <= "9");
    assign w_alnum = w_alpha || w_digit;
    assign w_grown = (r_run_len == '1) ? r_run_len : r_run_len + LB'(1);
    assign w_close = (w_c == (r_qdouble ? "\"" : "'"));

    always_comb begin
        ext_take = 1'b0;
        ext_fin  = 1'b0;
        ext_kind = sttok_pkg::P_BANG;
        ext_next = r_mode;
        case (r_mode)
            sttok_pkg::M_SLASH: begin
                if (w_c == "/") begin
                    ext_take = 1'b1; ext_next = sttok_pkg::M_LINE;
                end else if (w_c == "*") begin
                    ext_take = 1'b1; ext_next = sttok_pkg::M_BLOCK;
                end else if (w_c == "=") begin
                    ext_fin = 1'b1; ext_kind = sttok_pkg::P_SLASH_EQ;
                end
            end
            sttok_pkg::M_COLON: begin
                if (w_c == ":") begin
                    ext_fin = 1'b1; ext_kind = sttok_pkg::P_SCOPE;
                end
            end
            sttok_pkg::M_DOT1: begin
                if (w_digit) begin
                    ext_take = 1'b1; ext_next = sttok_pkg::M_NUMBER;
                end else if (w_c == ".") begin
                    ext_take = 1'b1; ext_next = sttok_pkg::M_DOT2;
                end
            end
            sttok_pkg::M_DOT2: begin
                if (w_c == ".") begin
                    ext_fin = 1'b1; ext_kind = sttok_pkg::P_ELLIPSIS;
                end
            end
            sttok_pkg::M_LT: begin
                if (w_c == "<") begin
                    ext_take = 1'b1; ext_next = sttok_pkg::M_LT2;
                end else if (w_c == "=") begin
                    ext_fin = 1'b1; ext_kind = sttok_pkg::P_LE;
                end
            end
            sttok_pkg::M_LT2: begin
                if (w_c == "=") begin
                    ext_fin = 1'b1; ext_kind = sttok_pkg::P_SHL_EQ;
                end
            end
            sttok_pkg::M_GT: begin
                if (w_c == ">") begin
                    ext_take = 1'b1; ext_next = sttok_pkg::M_GT2;
                end else if (w_c == "=") begin
                    ext_fin = 1'b1; ext_kind = sttok_pkg::P_GE;
                end
            end
            sttok_pkg::M_GT2: begin
                if (w_c == "=") begin
                    ext_fin = 1'b1; ext_kind = sttok_pkg::P_SHR_EQ;
                end
            end
            sttok_pkg::M_DOLLAR: begin
                if (w_c == "=") begin
                    ext_fin = 1'b1; ext_kind = sttok_pkg::P_MOD_EQ;
                end
            end
            sttok_pkg::M_CARET: begin
                if (w_c == "=") begin
                    ext_fin = 1'b1; ext_kind = sttok_pkg::P_XOR_EQ;
                end
            end
            sttok_pkg::M_AMP: begin
                if (w_c == "&") begin
                    ext_take = 1'b1; ext_next = sttok_pkg::M_AMP2;
                end else if (w_c == "=") begin
                    ext_fin = 1'b1; ext_kind = sttok_pkg::P_AND_EQ;
                end
            end
            sttok_pkg::M_AMP2: begin
                if (w_c == "=") begin
                    ext_fin = 1'b1; ext_kind = sttok_pkg::P_LAND_EQ;
                end
            end
            sttok_pkg::M_STAR: begin
                if (w_c == "=") begin
                    ext_fin = 1'b1; ext_kind = sttok_pkg::P_STAR_EQ;
                end
            end
            sttok_pkg::M_MINUS: begin
                if (w_c == "=") begin
                    ext_fin = 1'b1; ext_kind = sttok_pkg::P_MINUS_EQ;
                end else if (w_c == ">") begin
                    ext_fin = 1'b1; ext_kind = sttok_pkg::P_ARROW;
                end
            end
            sttok_pkg::M_EQ: begin
                if (w_c == "=") begin
                    ext_fin = 1'b1; ext_kind = sttok_pkg::P_EQEQ;
                end else if (w_c == ">") begin
                    ext_fin = 1'b1; ext_kind = sttok_pkg::P_DARROW;
                end
            end
            sttok_pkg::M_PIPE: begin
                if (w_c == "|") begin
                    ext_take = 1'b1; ext_next = sttok_pkg::M_PIPE2;
                end else if (w_c == "=") begin
                    ext_fin = 1'b1; ext_kind = sttok_pkg::P_OR_EQ;
                end
            end
            sttok_pkg::M_PIPE2: begin
                if (w_c == "=") begin
                    ext_fin = 1'b1; ext_kind = sttok_pkg::P_LOR_EQ;
                end
            end
            sttok_pkg::M_PLUS: begin
                if (w_c == "=") begin
                    ext_fin = 1'b1; ext_kind = sttok_pkg::P_PLUS_EQ;
                end
            end
            sttok_pkg::M_BANG: begin
                if (w_c == "=") begin
                    ext_fin = 1'b1; ext_kind = sttok_pkg::P_NE;
                end
            end
            default: begin
                ext_take = 1'b0;
            end
        endcase
        // A finished punctuator has taken the byte as well.
        if (ext_fin) begin
            ext_take = 1'b1;
        end
    end

    always_comb begin
        s_open = 1'b0;
        s_emit = 1'b0;
        s_kind = sttok_pkg::K_INVALID;
        s_mode = sttok_pkg::M_IDLE;
        if (w_c <= " ") begin
            s_open = 1'b0;
        end else if (w_alpha) begin
            s_open = 1'b1; s_mode = sttok_pkg::M_IDENT;
        end else if (w_digit) begin
            s_open = 1'b1; s_mode = sttok_pkg::M_NUMBER;
        end else begin
            unique case (w_c) inside
                "(":      begin s_emit = 1'b1; s_kind = sttok_pkg::P_LPAREN; end
                ")":      begin s_emit = 1'b1; s_kind = sttok_pkg::P_RPAREN; end
                "[":      begin s_emit = 1'b1; s_kind = sttok_pkg::P_LBRACK; end
                "]":      begin s_emit = 1'b1; s_kind = sttok_pkg::P_RBRACK; end
                "{":      begin s_emit = 1'b1; s_kind = sttok_pkg::P_LBRACE; end
                "}":      begin s_emit = 1'b1; s_kind = sttok_pkg::P_RBRACE; end
                ",":      begin s_emit = 1'b1; s_kind = sttok_pkg::P_COMMA; end
                ";":      begin s_emit = 1'b1; s_kind = sttok_pkg::P_SEMI; end
                "?":      begin s_emit = 1'b1; s_kind = sttok_pkg::P_QUEST; end
                "'", "\"": begin s_open = 1'b1; s_mode = sttok_pkg::M_QUOTE; end
                ".":      begin s_open = 1'b1; s_mode = sttok_pkg::M_DOT1; end
                "/":      begin s_open = 1'b1; s_mode = sttok_pkg::M_SLASH; end
                ":":      begin s_open = 1'b1; s_mode = sttok_pkg::M_COLON; end
                "<":      begin s_open = 1'b1; s_mode = sttok_pkg::M_LT; end
                ">":      begin s_open = 1'b1; s_mode = sttok_pkg::M_GT; end
                "$":      begin s_open = 1'b1; s_mode = sttok_pkg::M_DOLLAR; end
                "^":      begin s_open = 1'b1; s_mode = sttok_pkg::M_CARET; end
                "&":      begin s_open = 1'b1; s_mode = sttok_pkg::M_AMP; end
                "*":      begin s_open = 1'b1; s_mode = sttok_pkg::M_STAR; end
                "-":      begin s_open = 1'b1; s_mode = sttok_pkg::M_MINUS; end
                "=":      begin s_open = 1'b1; s_mode = sttok_pkg::M_EQ; end
                "|":      begin s_open = 1'b1; s_mode = sttok_pkg::M_PIPE; end
                "+":      begin s_open = 1'b1; s_mode = sttok_pkg::M_PLUS; end
                "!":      begin s_open = 1'b1; s_mode = sttok_pkg::M_BANG; end
                default:  begin s_emit = 1'b1; s_kind = sttok_pkg::K_INVALID; end
            endcase
        end
    end

    // The byte ends the pending token (or none is pending) and is decoded as a new token start.
    always_comb begin
        case (r_mode) inside
            sttok_pkg::M_IDLE:   w_restart = 1'b1;
            sttok_pkg::M_IDENT:  w_restart = !w_alnum;
            sttok_pkg::M_NUMBER: w_restart = !(w_digit || (w_c == "." && !r_dot_seen));
            sttok_pkg::M_QUOTE,
            sttok_pkg::M_LINE,
            sttok_pkg::M_BLOCK:  w_restart = 1'b0;
            default:             w_restart = !ext_take;
        endcase
    end

    // Next state.
    always_comb begin
        n_mode      = r_mode;
        n_byte_pos  = r_byte_pos;
        n_tok_start = r_tok_start;
        n_run_len   = r_run_len;
        n_escape    = r_escape;
        n_qdouble   = r_qdouble;
        n_dot_seen  = r_dot_seen;
        n_star_seen = r_star_seen;
        if (w_eot) begin
            n_mode      = sttok_pkg::M_IDLE;
            n_byte_pos  = '0;
            n_tok_start = '0;
            n_run_len   = '0;
            n_escape    = 1'b0;
            n_qdouble   = 1'b0;
            n_dot_seen  = 1'b0;
            n_star_seen = 1'b0;
        end else begin
            unique case (r_mode)
                sttok_pkg::M_IDLE: begin
                    n_mode = sttok_pkg::M_IDLE;
                end
                sttok_pkg::M_IDENT: begin
                    if (w_alnum) begin
                        n_run_len = w_grown;
                    end
                end
                sttok_pkg::M_NUMBER: begin
                    if (w_digit) begin
                        n_run_len = w_grown;
                    end else if (w_c == "." && !r_dot_seen) begin
                        n_dot_seen = 1'b1;
                        n_run_len  = w_grown;
                    end
                end
                sttok_pkg::M_QUOTE: begin
                    n_run_len = w_grown;
                    if (r_escape) begin
                        n_escape = 1'b0;
                    end else if (w_c == "\\") begin
                        n_escape = 1'b1;
                    end else if (w_close) begin
                        n_mode    = sttok_pkg::M_IDLE;
                        n_run_len = '0;
                    end
                end
                sttok_pkg::M_LINE: begin
                    if (w_c == "\n") begin
                        n_mode    = sttok_pkg::M_IDLE;
                        n_run_len = '0;
                    end
                end
                sttok_pkg::M_BLOCK: begin
                    if (w_c == "/" && r_star_seen) begin
                        n_mode      = sttok_pkg::M_IDLE;
                        n_run_len   = '0;
                        n_star_seen = 1'b0;
                    end else begin
                        n_star_seen = (w_c == "*");
                    end
                end
                default: begin
                    if (ext_fin) begin
                        n_mode    = sttok_pkg::M_IDLE;
                        n_run_len = '0;
                    end else if (ext_take) begin
                        n_mode = ext_next;
                        if (ext_next == sttok_pkg::M_NUMBER) begin
                            // A leading dot followed by a digit becomes a float.
                            n_dot_seen = 1'b1;
                            n_run_len  = LB'(2);
                        end else if (ext_next == sttok_pkg::M_LINE ||
                                     ext_next == sttok_pkg::M_BLOCK) begin
                            n_run_len   = '0;
                            n_star_seen = 1'b0;
                        end
                    end
                end
            endcase
            if (w_restart) begin
                n_mode    = sttok_pkg::M_IDLE;
                n_run_len = '0;
                if (s_open) begin
                    n_mode      = s_mode;
                    n_tok_start = r_byte_pos;
                    n_run_len   = LB'(1);
                    if (s_mode == sttok_pkg::M_NUMBER) begin
                        n_dot_seen = 1'b0;
                    end
                    if (s_mode == sttok_pkg::M_QUOTE) begin
                        n_qdouble = (w_c == "\"");
                        n_escape  = 1'b0;
                    end
                end
            end
            if (r_byte_pos != '1) begin
                n_byte_pos = r_byte_pos + OB'(1);
            end
        end
    end

    // Tokens caused by the byte.
    always_comb begin
        a_vld   = 1'b0;
        a_kind  = sttok_pkg::K_END;
        a_start = r_tok_start;
        a_len   = r_run_len;
        b_vld   = 1'b0;
        b_kind  = sttok_pkg::K_END;
        b_start = r_byte_pos;
        b_len   = '0;
        if (w_eot) begin
            unique case (r_mode) inside
                sttok_pkg::M_IDLE, sttok_pkg::M_LINE, sttok_pkg::M_BLOCK: begin
                    a_vld = 1'b0;
                end
                sttok_pkg::M_IDENT: begin
                    a_vld = 1'b1; a_kind = sttok_pkg::K_IDENT;
                end
                sttok_pkg::M_NUMBER: begin
                    a_vld  = 1'b1;
                    a_kind = r_dot_seen ? sttok_pkg::K_FLOAT : sttok_pkg::K_INT;
                end
                sttok_pkg::M_QUOTE: begin
                    a_vld = 1'b1; a_kind = sttok_pkg::K_UNTERM;
                end
                default: begin
                    a_vld  = 1'b1;
                    a_kind = held_kind(r_mode);
                    a_len  = held_len(r_mode);
                end
            endcase
            b_vld = 1'b1;
        end else begin
            unique case (r_mode) inside
                sttok_pkg::M_IDLE, sttok_pkg::M_LINE, sttok_pkg::M_BLOCK: begin
                    a_vld = 1'b0;
                end
                sttok_pkg::M_IDENT: begin
                    a_vld = w_restart; a_kind = sttok_pkg::K_IDENT;
                end
                sttok_pkg::M_NUMBER: begin
                    a_vld  = w_restart;
                    a_kind = r_dot_seen ? sttok_pkg::K_FLOAT : sttok_pkg::K_INT;
                end
                sttok_pkg::M_QUOTE: begin
                    a_vld  = !r_escape && (w_c != "\\") && w_close;
                    a_kind = r_qdouble ? sttok_pkg::K_STRING : sttok_pkg::K_CHAR;
                    a_len  = w_grown;
                end
                default: begin
                    if (ext_fin) begin
                        a_vld  = 1'b1;
                        a_kind = ext_kind;
                        a_len  = held_len(r_mode) + LB'(1);
                    end else if (!ext_take) begin
                        a_vld  = 1'b1;
                        a_kind = held_kind(r_mode);
                        a_len  = held_len(r_mode);
                    end
                end
            endcase
            b_vld  = w_restart && s_emit;
            b_kind = s_kind;
            b_len  = LB'(1);
        end

        w_res1 = '{token_kind: b_kind, start_offset: b_start, token_length: b_len,
                   last_of_run: 1'b1};
        if (a_vld) begin
            w_res0 = '{token_kind: a_kind, start_offset: a_start, token_length: a_len,
                       last_of_run: !b_vld};
            w_nres = b_vld ? 2'd2 : 2'd1;
        end else begin
            w_res0 = w_res1;
            w_nres = b_vld ? 2'd1 : 2'd0;
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_in_acc) begin
            n_count = n_count + sttok_pkg::OQ_CNT_BITS'(w_nres);
        end
        if (w_out_acc) begin
            n_count = n_count - sttok_pkg::OQ_CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= sttok_pkg::M_IDLE;
            r_byte_pos  <= '0;
            r_tok_start <= '0;
            r_run_len   <= '0;
            r_escape    <= 1'b0;
            r_qdouble   <= 1'b0;
            r_dot_seen  <= 1'b0;
            r_star_seen <= 1'b0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
        end else begin
            if (w_in_acc) begin
                r_mode      <= n_mode;
                r_byte_pos  <= n_byte_pos;
                r_tok_start <= n_tok_start;
                r_run_len   <= n_run_len;
                r_escape    <= n_escape;
                r_qdouble   <= n_qdouble;
                r_dot_seen  <= n_dot_seen;
                r_star_seen <= n_star_seen;
                r_wr_ptr    <= r_wr_ptr + sttok_pkg::OQ_PTR_BITS'(w_nres);
            end
            if (w_out_acc) begin
                r_rd_ptr <= r_rd_ptr + sttok_pkg::OQ_PTR_BITS'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_nres != 2'd0) begin
            r_oq[r_wr_ptr] <= w_res0;
        end
        if (w_in_acc && w_nres == 2'd2) begin
            r_oq[r_wr_ptr + sttok_pkg::OQ_PTR_BITS'(1)] <= w_res1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sttok_pkg::OQ_CNT_BITS'(sttok_pkg::OQ_DEPTH))
        else $error("result queue count beyond its depth");

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && w_eot |=> r_byte_pos == '0 && r_mode == sttok_pkg::M_IDLE)
        else $error("lexer not back at offset zero after the end token");

    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && w_eot |-> w_nres != 2'd0)
        else $error("end of text produced no token");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !w_eot && r_byte_pos != '1 |=>
        r_byte_pos == $past(r_byte_pos) + OB'(1))
        else $error("byte position did not advance by one");

    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == sttok_pkg::M_IDENT || r_mode == sttok_pkg::M_NUMBER ||
         r_mode == sttok_pkg::M_QUOTE) |-> r_run_len != '0)
        else $error("open token with zero length");

endmodule

`default_nettype wire
